>>> hw/rtl/uxw_pkg.sv
// Shared types, constants and the code point width classifier for the
// UTF-8 tab expander. No dependencies; used by every module of the block.
package uxw_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0]  SPACE_BYTE = 8'h20;
    localparam logic [20:0] CP_TAB     = 21'd9;
    localparam logic [20:0] CP_REPL    = 21'h0FFFD;

    // One queue entry: every settle caused by one input transaction.
    typedef struct packed {
        logic            a_valid;
        logic            a_tab;
        logic [1:0]      a_cols;
        logic [1:0]      a_last;
        logic [3:0][7:0] a_bytes;
        logic            b_valid;
        logic            b_tab;
        logic [1:0]      b_cols;
        logic [7:0]      b_byte;
        logic            empty;
        logic            cell_end;
    } uxw_pkt_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_A_TAB,
        BK_A_BYTES,
        BK_B_TAB,
        BK_B_BYTE,
        BK_EMPTY
    } bk_state_t;

    function automatic logic [1:0] cp_columns(input logic [20:0] cp);
        logic zero_w;
        logic wide;
        zero_w = (cp < 21'h00020) || (cp == 21'h0007F)
              || (cp >= 21'h00300 && cp <= 21'h0036F)
              || (cp >= 21'h01AB0 && cp <= 21'h01AFF)
              || (cp >= 21'h01DC0 && cp <= 21'h01DFF)
              || (cp >= 21'h020D0 && cp <= 21'h020FF)
              || (cp >= 21'h0FE20 && cp <= 21'h0FE2F)
              || (cp >= 21'h0200C && cp <= 21'h0200D)
              || (cp >= 21'h0FE00 && cp <= 21'h0FE0F);
        wide   = (cp >= 21'h01100 && cp <= 21'h0115F)
              || (cp >= 21'h02329 && cp <= 21'h0232A)
              || (cp >= 21'h02E80 && cp <= 21'h0A4CF)
              || (cp >= 21'h0AC00 && cp <= 21'h0D7A3)
              || (cp >= 21'h0F900 && cp <= 21'h0FAFF)
              || (cp >= 21'h0FE10 && cp <= 21'h0FE19)
              || (cp >= 21'h0FE30 && cp <= 21'h0FE6F)
              || (cp >= 21'h0FF00 && cp <= 21'h0FF60)
              || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6)
              || (cp >= 21'h1F300 && cp <= 21'h1FAFF)
              || (cp >= 21'h02600 && cp <= 21'h026FF)
              || (cp >= 21'h02700 && cp <= 21'h027BF);
        if (zero_w) begin
            cp_columns = 2'd0;
        end else if (wide) begin
            cp_columns = 2'd2;
        end else begin
            cp_columns = 2'd1;
        end
    endfunction

endpackage

>>> hw/rtl/utf8_tab_expand_width.sv
// UTF-8 tab expander and display width counter, top level.
// Instantiates uxw_front, uxw_queue and uxw_back; depends on uxw_pkg.
//
// The block takes one input transaction per cycle unless its queue is full and
// produces one result per cycle while out_ready holds. Most bytes give exactly
// one result, so plain text runs at one byte per clock without stalls. A tab
// expands into 1 to TAB_STOP space results, and a byte that completes or
// interrupts a multi-byte sequence releases all held bytes, one result per
// cycle each; the back end's one-result-per-cycle walk sets these figures,
// and the two-entry queue lets the input keep flowing while a burst drains.
// Results past the sixteenth for one input are dropped but still counted for
// their column effect. The output register holds a result until it is taken.
module utf8_tab_expand_width #(
    parameter int TAB_STOP    = 8,
    parameter int COLUMN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        cell_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last_of_run,
    output logic [15:0] cell_width,
    output logic        width_overflow
);

    uxw_pkg::uxw_pkt_t push_pkt, head_pkt;
    logic q_push, q_full, head_valid, q_pop;

    uxw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .cell_end  (cell_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_pkt     (push_pkt)
    );

    uxw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_pkt   (push_pkt),
        .full       (q_full),
        .head_valid (head_valid),
        .head_pkt   (head_pkt),
        .pop        (q_pop)
    );

    uxw_back #(
        .TAB_STOP    (TAB_STOP),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (head_valid),
        .q_pkt          (head_pkt),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .cell_width     (cell_width),
        .width_overflow (width_overflow)
    );

endmodule

>>> hw/rtl/uxw_front.sv
// Front end: accepts input transactions, runs the UTF-8 decoder state and
// classifies settled code points into queue entries. Depends on uxw_pkg.
module uxw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              has_byte,
    input  logic              cell_end,
    input  logic              q_full,
    output logic              q_push,
    output uxw_pkg::uxw_pkt_t q_pkt
);

    logic [7:0]  held_reg [3];
    logic [1:0]  held_cnt_reg, cnt_next;
    logic [1:0]  expect_reg, exp_next;
    logic [20:0] part_reg, part_next;

    logic            accept, pend, is_cont, is_asc, lead2, lead3, lead4;
    logic [20:0]     cp_cont, lead_cp, a_cp, b_cp;
    logic            a_valid, b_valid, empty;
    logic [2:0]      a_cnt;
    logic            hold_we;
    logic [1:0]      hold_idx;
    logic [3:0][7:0] a_bytes;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pend     = (expect_reg != 2'd0);
    assign is_cont  = (data_byte[7:6] == 2'b10);
    assign is_asc   = !data_byte[7];
    assign lead2    = (data_byte[7:5] == 3'b110);
    assign lead3    = (data_byte[7:4] == 4'b1110);
    assign lead4    = (data_byte[7:3] == 5'b11110);
    assign cp_cont  = {part_reg[14:0], data_byte[5:0]};

    always_comb
    begin
        if (lead2) begin
            lead_cp = {16'd0, data_byte[4:0]};
        end else if (lead3) begin
            lead_cp = {17'd0, data_byte[3:0]};
        end else begin
            lead_cp = {18'd0, data_byte[2:0]};
        end
    end

    always_comb
    begin
        a_bytes[0] = (held_cnt_reg > 2'd0) ? held_reg[0] : data_byte;
        a_bytes[1] = (held_cnt_reg > 2'd1) ? held_reg[1] : data_byte;
        a_bytes[2] = (held_cnt_reg > 2'd2) ? held_reg[2] : data_byte;
        a_bytes[3] = data_byte;
    end

    always_comb
    begin
        a_valid   = 1'b0;
        a_cp      = part_reg;
        a_cnt     = {1'b0, held_cnt_reg};
        b_valid   = 1'b0;
        b_cp      = {13'd0, data_byte};
        cnt_next  = held_cnt_reg;
        exp_next  = expect_reg;
        part_next = part_reg;
        hold_we   = 1'b0;
        hold_idx  = held_cnt_reg;
        if (has_byte) begin
            if (pend && is_cont) begin
                if (expect_reg == 2'd1) begin
                    a_valid   = 1'b1;
                    a_cp      = cp_cont;
                    a_cnt     = {1'b0, held_cnt_reg} + 3'd1;
                    cnt_next  = 2'd0;
                    exp_next  = 2'd0;
                    part_next = '0;
                end else begin
                    hold_we   = 1'b1;
                    cnt_next  = held_cnt_reg + 2'd1;
                    exp_next  = expect_reg - 2'd1;
                    part_next = cp_cont;
                end
            end else begin
                if (pend) begin
                    a_valid = 1'b1;
                    a_cp    = part_reg;
                    a_cnt   = {1'b0, held_cnt_reg};
                end
                cnt_next  = 2'd0;
                exp_next  = 2'd0;
                part_next = '0;
                if (lead2 || lead3 || lead4) begin
                    hold_we   = 1'b1;
                    hold_idx  = 2'd0;
                    cnt_next  = 2'd1;
                    exp_next  = lead2 ? 2'd1 : (lead3 ? 2'd2 : 2'd3);
                    part_next = lead_cp;
                end else begin
                    b_valid = 1'b1;
                    b_cp    = is_asc ? {13'd0, data_byte} : uxw_pkg::CP_REPL;
                end
            end
        end
        // flush the pending sequence at cell end
        if (cell_end && exp_next != 2'd0) begin
            if (!a_valid) begin
                a_valid = 1'b1;
                a_cnt   = {1'b0, cnt_next};
                a_cp    = part_next;
            end else begin
                b_valid = 1'b1;
                b_cp    = part_next;
            end
        end
        if (cell_end) begin
            cnt_next  = 2'd0;
            exp_next  = 2'd0;
            part_next = '0;
        end
        empty = cell_end && !a_valid && !b_valid;
    end

    always_comb
    begin
        q_pkt.a_valid  = a_valid;
        q_pkt.a_tab    = (a_cp == uxw_pkg::CP_TAB);
        q_pkt.a_cols   = uxw_pkg::cp_columns(a_cp);
        q_pkt.a_last   = 2'(a_cnt - 3'd1);
        q_pkt.a_bytes  = a_bytes;
        q_pkt.b_valid  = b_valid;
        q_pkt.b_tab    = (b_cp == uxw_pkg::CP_TAB);
        q_pkt.b_cols   = uxw_pkg::cp_columns(b_cp);
        q_pkt.b_byte   = data_byte;
        q_pkt.empty    = empty;
        q_pkt.cell_end = cell_end;
        q_push         = accept && (a_valid || b_valid || empty);
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we) begin
            held_reg[hold_idx] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_cnt_reg <= 2'd0;
            expect_reg   <= 2'd0;
            part_reg     <= '0;
        end else if (accept) begin
            held_cnt_reg <= cnt_next;
            expect_reg   <= exp_next;
            part_reg     <= part_next;
        end
    end

endmodule

>>> hw/rtl/uxw_queue.sv
// Short register queue between the decoder front end and the output back end.
// Depends on uxw_pkg for the entry type and depth.
module uxw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uxw_pkg::uxw_pkt_t push_pkt,
    output logic              full,
    output logic              head_valid,
    output uxw_pkg::uxw_pkt_t head_pkt,
    input  logic              pop
);

    uxw_pkg::uxw_pkt_t mem_reg [uxw_pkg::QDEPTH];
    logic [uxw_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [uxw_pkg::QCNT_W-1:0] count_reg;

    assign full       = (count_reg == uxw_pkg::QCNT_W'(uxw_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + uxw_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + uxw_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + uxw_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - uxw_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/uxw_back.sv
// Back end: walks queue entries one result per cycle when unstalled, expands
// tabs, keeps the display column, drives the output register. Uses uxw_pkg.
module uxw_back #(
    parameter int TAB_STOP    = 8,
    parameter int COLUMN_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  uxw_pkg::uxw_pkt_t q_pkt,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              last_of_run,
    output logic [15:0]       cell_width,
    output logic              width_overflow
);

    localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int TC_W = $clog2(TAB_STOP + 1);
    localparam int PS_W = PH_W + 2;
    localparam logic [32:0] COL_MAX_W = (33'd1 << COLUMN_BITS) - 33'd1;
    localparam logic [PH_W-1:0] PH_AT_MAX = PH_W'(COL_MAX_W % TAB_STOP);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
    localparam logic [TC_W-1:0] TS_C = TC_W'(TAB_STOP);
    localparam logic [PS_W-1:0] TS_P = PS_W'(TAB_STOP);
    localparam logic [4:0] RUN_CAP = 5'(uxw_pkg::MAX_RESULTS - 1);
    localparam logic [4:0] RUN_OVER = 5'(uxw_pkg::MAX_RESULTS);

    uxw_pkg::bk_state_t state_reg, state_next, first_state;
    uxw_pkg::uxw_pkt_t  pkt_reg, pkt_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   tab_first_reg, tab_first_next;
    logic [TC_W-1:0]        tab_left_reg, tab_left_next, tab_n;
    logic [4:0]             run_reg, run_next;
    logic [7:0]             cap_reg, cap_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, col_upd;
    logic                   sat_reg, sat_next, sat_upd;
    logic [PH_W-1:0]        phase_reg, phase_next, phase_upd;

    logic        ov_reg, ov_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        obv_reg, obv_next;
    logic        olast_reg, olast_next;
    logic [15:0] owidth_reg, owidth_next;
    logic        oovf_reg, oovf_next;

    logic                 adv, seg_done, raw_last, raw_bv, load;
    logic                 emit_norm, emit_cap, capture, in_a;
    logic [7:0]           raw_byte;
    logic [1:0]           add_n;
    logic [COLUMN_BITS:0] col_sum;
    logic [PS_W-1:0]      ph_sum;
    logic [32:0]          col_ext;
    logic [15:0]          width_now;
    logic                 ovf_now;

    assign out_valid      = ov_reg;
    assign out_byte       = obyte_reg;
    assign byte_valid     = obv_reg;
    assign last_of_run    = olast_reg;
    assign cell_width     = owidth_reg;
    assign width_overflow = oovf_reg;
    assign q_pop          = load;

    always_comb
    begin
        adv   = (state_reg != uxw_pkg::BK_IDLE) && (!ov_reg || out_ready);
        tab_n = tab_first_reg ? (TS_C - TC_W'(phase_reg)) : tab_left_reg;
        in_a  = 1'b0;
        unique case (state_reg) inside
            uxw_pkg::BK_A_TAB, uxw_pkg::BK_B_TAB:
            begin
                add_n    = 2'd1;
                raw_byte = uxw_pkg::SPACE_BYTE;
                raw_bv   = 1'b1;
                seg_done = (tab_n == TC_W'(1));
                in_a     = (state_reg == uxw_pkg::BK_A_TAB);
            end
            uxw_pkg::BK_A_BYTES:
            begin
                add_n    = (idx_reg == 2'd0) ? pkt_reg.a_cols : 2'd0;
                raw_byte = pkt_reg.a_bytes[idx_reg];
                raw_bv   = 1'b1;
                seg_done = (idx_reg == pkt_reg.a_last);
                in_a     = 1'b1;
            end
            uxw_pkg::BK_B_BYTE:
            begin
                add_n    = pkt_reg.b_cols;
                raw_byte = pkt_reg.b_byte;
                raw_bv   = 1'b1;
                seg_done = 1'b1;
            end
            uxw_pkg::BK_EMPTY:
            begin
                add_n    = 2'd0;
                raw_byte = 8'h00;
                raw_bv   = 1'b0;
                seg_done = 1'b1;
            end
            default:
            begin
                add_n    = 2'd0;
                raw_byte = 8'h00;
                raw_bv   = 1'b0;
                seg_done = 1'b0;
            end
        endcase
        raw_last = seg_done && !(in_a && pkt_reg.b_valid);
        load     = q_valid && ((state_reg == uxw_pkg::BK_IDLE) || (adv && raw_last));

        col_sum = {1'b0, col_reg} + (COLUMN_BITS + 1)'(add_n);
        ph_sum  = PS_W'(phase_reg) + PS_W'(add_n);
        if (ph_sum >= TS_P) begin
            ph_sum = ph_sum - TS_P;
        end
        if (ph_sum >= TS_P) begin
            ph_sum = ph_sum - TS_P;
        end
        if (col_sum[COLUMN_BITS]) begin
            col_upd   = COL_MAX;
            sat_upd   = 1'b1;
            phase_upd = PH_AT_MAX;
        end else begin
            col_upd   = col_sum[COLUMN_BITS-1:0];
            sat_upd   = sat_reg;
            phase_upd = ph_sum[PH_W-1:0];
        end
        col_ext = 33'(col_upd);
        if (col_ext > 33'h0FFFF) begin
            width_now = 16'hFFFF;
            ovf_now   = 1'b1;
        end else begin
            width_now = col_ext[15:0];
            ovf_now   = sat_upd;
        end

        emit_norm = (run_reg < RUN_CAP) || ((run_reg == RUN_CAP) && raw_last);
        capture   = (run_reg == RUN_CAP) && !raw_last;
        emit_cap  = (run_reg == RUN_OVER) && raw_last;

        pkt_next       = pkt_reg;
        idx_next       = idx_reg;
        tab_first_next = tab_first_reg;
        tab_left_next  = tab_left_reg;
        run_next       = run_reg;
        cap_next       = cap_reg;
        col_next       = col_reg;
        sat_next       = sat_reg;
        phase_next     = phase_reg;
        if (adv) begin
            col_next   = col_upd;
            sat_next   = sat_upd;
            phase_next = phase_upd;
            if (raw_last && pkt_reg.cell_end) begin
                col_next   = '0;
                sat_next   = 1'b0;
                phase_next = '0;
            end
            if (capture) begin
                cap_next = raw_byte;
            end
            if (run_reg != RUN_OVER) begin
                run_next = run_reg + 5'd1;
            end
            if (seg_done) begin
                idx_next       = 2'd0;
                tab_first_next = 1'b1;
            end else begin
                idx_next       = idx_reg + 2'd1;
                tab_first_next = 1'b0;
                tab_left_next  = tab_n - TC_W'(1);
            end
        end
        if (load) begin
            pkt_next       = q_pkt;
            idx_next       = 2'd0;
            tab_first_next = 1'b1;
            run_next       = 5'd0;
        end

        ov_next     = ov_reg;
        obyte_next  = obyte_reg;
        obv_next    = obv_reg;
        olast_next  = olast_reg;
        owidth_next = owidth_reg;
        oovf_next   = oovf_reg;
        if (adv) begin
            ov_next = emit_norm || emit_cap;
            if (emit_norm || emit_cap) begin
                obyte_next  = emit_cap ? cap_reg : raw_byte;
                obv_next    = emit_cap || raw_bv;
                olast_next  = raw_last;
                owidth_next = width_now;
                oovf_next   = ovf_now;
            end
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_comb
    begin
        if (q_pkt.a_valid) begin
            first_state = q_pkt.a_tab ? uxw_pkg::BK_A_TAB : uxw_pkg::BK_A_BYTES;
        end else if (q_pkt.b_valid) begin
            first_state = q_pkt.b_tab ? uxw_pkg::BK_B_TAB : uxw_pkg::BK_B_BYTE;
        end else begin
            first_state = uxw_pkg::BK_EMPTY;
        end
        state_next = state_reg;
        if (adv && seg_done) begin
            unique case (state_reg) inside
                uxw_pkg::BK_A_TAB, uxw_pkg::BK_A_BYTES:
                begin
                    if (pkt_reg.b_valid) begin
                        state_next = pkt_reg.b_tab ? uxw_pkg::BK_B_TAB : uxw_pkg::BK_B_BYTE;
                    end else begin
                        state_next = uxw_pkg::BK_IDLE;
                    end
                end
                default:
                begin
                    state_next = uxw_pkg::BK_IDLE;
                end
            endcase
        end
        if (load) begin
            state_next = first_state;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg    <= pkt_next;
        cap_reg    <= cap_next;
        obyte_reg  <= obyte_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
        owidth_reg <= owidth_next;
        oovf_reg   <= oovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= uxw_pkg::BK_IDLE;
            idx_reg       <= 2'd0;
            tab_first_reg <= 1'b1;
            tab_left_reg  <= '0;
            run_reg       <= 5'd0;
            col_reg       <= '0;
            sat_reg       <= 1'b0;
            phase_reg     <= '0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tab_first_reg <= tab_first_next;
            tab_left_reg  <= tab_left_next;
            run_reg       <= run_next;
            col_reg       <= col_next;
            sat_reg       <= sat_next;
            phase_reg     <= phase_next;
            ov_reg        <= ov_next;
        end
    end

endmodule

>>> hw/rtl/uxw_checker.sv
// Port-level checker for utf8_tab_expand_width, with its bind statement.
// Depends only on the top level's ports and its COLUMN_BITS parameter.
module uxw_checker #(
    parameter int COLUMN_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        has_byte,
    input logic        cell_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        last_of_run,
    input logic [15:0] cell_width,
    input logic        width_overflow
);

    localparam logic [15:0] WMAX = (COLUMN_BITS >= 16) ? 16'hFFFF
                                 : 16'((32'd1 << COLUMN_BITS) - 32'd1);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({data_byte, has_byte, cell_end}))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({out_byte, byte_valid, last_of_run, cell_width, width_overflow}))
        else $error("output transaction changed while stalled");

    a_bare_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last_of_run && out_byte == 8'h00)
        else $error("bare width report is not a lone zero result");

    a_overflow_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && width_overflow |-> cell_width == WMAX)
        else $error("overflow flagged without a saturated width");

endmodule

bind utf8_tab_expand_width uxw_checker #(.COLUMN_BITS(COLUMN_BITS)) u_uxw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .cell_end       (cell_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_of_run    (last_of_run),
    .cell_width     (cell_width),
    .width_overflow (width_overflow)
);

>>> sim/tb.sv
// Self-checking testbench for utf8_tab_expand_width: UTF-8 decode, tab expansion and
// display-width count checked against an in-bench predictor, transaction by transaction.
// Depends only on the RTL top level; drives both valid/ready channels with random idling.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TAB_COLS      = 8;
    localparam int unsigned COL_MAX       = 32'd65535;
    localparam int          RUN_CAP       = 16;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          ITEMS_PER_SET = 130;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;
    localparam logic [20:0] CP_HTAB       = 21'd9;
    localparam logic [20:0] CP_REPLACE    = 21'h0FFFD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       cell_end;
    } text_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic [15:0] cell_width;
        logic        width_overflow;
    } cell_result_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = 8'h00;
    logic        has_byte       = 1'b0;
    logic        cell_end       = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic [15:0] cell_width;
    logic        width_overflow;

    text_item_t   text_items_q [$];
    cell_result_t expanded_results_q [$];
    cell_result_t item_results [$];

    logic [7:0]  held_seq [3];
    int          held_n      = 0;
    int          cont_left   = 0;
    logic [20:0] cp_acc      = 21'd0;
    int unsigned column      = 0;
    bit          col_sat     = 1'b0;

    int tx_idle_pct = 37;
    int rx_idle_pct = 58;
    int fill_count  = 0;
    int error_count = 0;
    int cycle_count = 0;

    utf8_tab_expand_width u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .cell_end       (cell_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .cell_width     (cell_width),
        .width_overflow (width_overflow)
    );

    always #5 clk = ~clk;

    function automatic bit in_span(logic [20:0] cp, int lo, int hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic bit is_zero_width(logic [20:0] cp);
        return in_span(cp, 'h0300, 'h036F) || in_span(cp, 'h1AB0, 'h1AFF)
            || in_span(cp, 'h1DC0, 'h1DFF) || in_span(cp, 'h20D0, 'h20FF)
            || in_span(cp, 'hFE20, 'hFE2F) || in_span(cp, 'h200C, 'h200D)
            || in_span(cp, 'hFE00, 'hFE0F);
    endfunction

    function automatic bit is_wide(logic [20:0] cp);
        return in_span(cp, 'h1100, 'h115F) || in_span(cp, 'h2329, 'h232A)
            || in_span(cp, 'h2E80, 'hA4CF) || in_span(cp, 'hAC00, 'hD7A3)
            || in_span(cp, 'hF900, 'hFAFF) || in_span(cp, 'hFE10, 'hFE19)
            || in_span(cp, 'hFE30, 'hFE6F) || in_span(cp, 'hFF00, 'hFF60)
            || in_span(cp, 'hFFE0, 'hFFE6) || in_span(cp, 'h1F300, 'h1FAFF)
            || in_span(cp, 'h2600, 'h26FF) || in_span(cp, 'h2700, 'h27BF);
    endfunction

    function automatic void emit_result(logic [7:0] b, bit valid);
        cell_result_t r;
        if (item_results.size() < RUN_CAP)
        begin
            r.out_byte       = valid ? b : 8'h00;
            r.byte_valid     = valid;
            r.last_of_run    = 1'b0;
            r.cell_width     = column[15:0];
            r.width_overflow = col_sat;
            item_results.insert(item_results.size(), r);
        end
    endfunction

    function automatic void advance_column(int unsigned n);
        if (column > COL_MAX - n)
        begin
            column  = COL_MAX;
            col_sat = 1'b1;
        end
        else
        begin
            column = column + n;
        end
    endfunction

    function automatic void settle_code_point(logic [20:0] cp, bit has_tail, logic [7:0] tail);
        int spaces;
        int k;
        if (cp == CP_HTAB)
        begin
            spaces = TAB_COLS - int'(column % TAB_COLS);
            for (k = 0; k < spaces; k++)
            begin
                advance_column(1);
                emit_result(SPACE_CHAR, 1'b1);
            end
        end
        else
        begin
            if (cp >= 21'h20 && cp != 21'h7F && !is_zero_width(cp))
                advance_column(is_wide(cp) ? 2 : 1);
            for (k = 0; k < held_n; k++)
                emit_result(held_seq[k], 1'b1);
            if (has_tail)
                emit_result(tail, 1'b1);
        end
        held_n    = 0;
        cont_left = 0;
        cp_acc    = 21'd0;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        if (cont_left > 0 && b[7:6] == 2'b10)
        begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 1;
            if (cont_left == 0)
            begin
                settle_code_point(cp_acc, 1'b1, b);
            end
            else if (held_n < 3)
            begin
                held_seq[held_n] = b;
                held_n = held_n + 1;
            end
        end
        else
        begin
            if (cont_left > 0)
                settle_code_point(cp_acc, 1'b0, 8'h00);
            if (b < 8'h80)
            begin
                settle_code_point({13'd0, b}, 1'b1, b);
            end
            else if (b[7:5] == 3'b110)
            begin
                held_seq[0] = b;
                held_n      = 1;
                cp_acc      = {16'd0, b[4:0]};
                cont_left   = 1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                held_seq[0] = b;
                held_n      = 1;
                cp_acc      = {17'd0, b[3:0]};
                cont_left   = 2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                held_seq[0] = b;
                held_n      = 1;
                cp_acc      = {18'd0, b[2:0]};
                cont_left   = 3;
            end
            else
            begin
                settle_code_point(CP_REPLACE, 1'b1, b);
            end
        end
    endfunction

    function automatic void expand_text_item(text_item_t it);
        cell_result_t r;
        item_results.delete();
        if (it.has_byte)
            decode_byte(it.data_byte);
        if (it.cell_end)
        begin
            if (cont_left > 0)
                settle_code_point(cp_acc, 1'b0, 8'h00);
            if (item_results.size() == 0)
                emit_result(8'h00, 1'b0);
        end
        if (item_results.size() > 0)
        begin
            r                = item_results[item_results.size() - 1];
            r.last_of_run    = 1'b1;
            r.cell_width     = column[15:0];
            r.width_overflow = col_sat;
            item_results[item_results.size() - 1] = r;
        end
        while (item_results.size() > 0)
            expanded_results_q.insert(expanded_results_q.size(), item_results.pop_front());
        if (it.cell_end)
        begin
            held_n    = 0;
            cont_left = 0;
            cp_acc    = 21'd0;
            column    = 0;
            col_sat   = 1'b0;
        end
    endfunction

    function automatic void queue_item(logic [7:0] b, bit hb, bit ce);
        text_item_t it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.cell_end  = ce;
        text_items_q.insert(text_items_q.size(), it);
        if (hb || ce)
            fill_count = fill_count + 1;
    endfunction

    function automatic void queue_text_byte(logic [7:0] b);
        queue_item(b, 1'b1, $urandom_range(0, 24) == 0);
    endfunction

    function automatic void queue_utf8(logic [20:0] cp, int nbytes, int keep);
        logic [7:0] seq [4];
        int i;
        case (nbytes)
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < keep; i++)
            queue_text_byte(seq[i]);
    endfunction

    function automatic logic [20:0] pick_bmp_cp();
        logic [20:0] cp;
        case ($urandom_range(0, 8))
            0: cp = 21'($urandom_range('h4E00, 'h9FFF));
            1: cp = 21'($urandom_range('hAC00, 'hD7A3));
            2: cp = 21'($urandom_range('hFE00, 'hFE6F));
            3: cp = 21'($urandom_range('h2000, 'h20FF));
            4: cp = 21'($urandom_range('h2300, 'h27FF));
            5: cp = 21'($urandom_range('hFF00, 'hFFFF));
            6: cp = 21'($urandom_range('h1100, 'h115F));
            7: cp = 21'($urandom_range('h1A00, 'h1DFF));
            default: cp = 21'($urandom_range(0, 'hFFFF));
        endcase
        return cp;
    endfunction

    function automatic void queue_random_text(int target);
        int          kind;
        int          nb;
        logic [20:0] cp;
        fill_count = 0;
        while (fill_count < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
                queue_text_byte(8'($urandom_range('h20, 'h7E)));
            else if (kind < 38)
                queue_text_byte(8'h09);
            else if (kind < 43)
                queue_text_byte($urandom_range(0, 3) == 0 ? 8'h7F
                                                          : 8'($urandom_range(0, 'h1F)));
            else if (kind < 51)
                queue_utf8(21'($urandom_range(0, 'h7FF)), 2, 2);
            else if (kind < 55)
                queue_utf8(21'($urandom_range('h300, 'h36F)), 2, 2);
            else if (kind < 70)
                queue_utf8(pick_bmp_cp(), 3, 3);
            else if (kind < 80)
            begin
                cp = $urandom_range(0, 1) ? 21'($urandom_range('h1F200, 'h1FBFF))
                                          : 21'($urandom_range(0, 'h1FFFFF));
                queue_utf8(cp, 4, 4);
            end
            else if (kind < 88)
            begin
                nb = int'($urandom_range(2, 4));
                cp = 21'($urandom_range(0, 'h1FFFFF));
                if (nb == 2 && $urandom_range(0, 1))
                    cp[10:6] = 5'd9;
                queue_utf8(cp, nb, int'($urandom_range(1, nb - 1)));
            end
            else if (kind < 93)
                queue_text_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                                     : 8'($urandom_range('hF8, 'hFF)));
            else
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic void queue_directed_text();
        queue_item(8'h41, 1'b1, 1'b0);
        queue_item(8'h09, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'h7F, 1'b1, 1'b0);
        queue_item(8'hC3, 1'b1, 1'b0);
        queue_item(8'hA9, 1'b1, 1'b0);
        queue_item(8'hE4, 1'b1, 1'b0);
        queue_item(8'hB8, 1'b1, 1'b0);
        queue_item(8'hAD, 1'b1, 1'b0);
        queue_item(8'hF0, 1'b1, 1'b0);
        queue_item(8'h9F, 1'b1, 1'b0);
        queue_item(8'h98, 1'b1, 1'b0);
        queue_item(8'h80, 1'b1, 1'b0);
        queue_item(8'hCC, 1'b1, 1'b0);
        queue_item(8'h81, 1'b1, 1'b0);
        queue_item(8'h80, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'hC9, 1'b1, 1'b0);
        queue_item(8'h41, 1'b1, 1'b0);
        queue_item(8'hE4, 1'b1, 1'b0);
        queue_item(8'hB8, 1'b1, 1'b0);
        queue_item(8'hA5, 1'b0, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'hC9, 1'b1, 1'b0);
        queue_item(8'h09, 1'b1, 1'b1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        text_item_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            has_byte  <= 1'b0;
            cell_end  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expand_text_item({data_byte, has_byte, cell_end});
            if (!in_valid || in_ready)
            begin
                if (text_items_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = text_items_q.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= nxt.data_byte;
                    has_byte  <= nxt.has_byte;
                    cell_end  <= nxt.cell_end;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        cell_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expanded_results_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %h cell_width %0d", out_byte, cell_width);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expanded_results_q.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, out_byte);
                        error_count = error_count + 1;
                    end
                    if (byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.byte_valid, byte_valid);
                        error_count = error_count + 1;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run);
                        error_count = error_count + 1;
                    end
                    if (cell_width !== want.cell_width)
                    begin
                        $error("cell_width: expected %0d, got %0d", want.cell_width, cell_width);
                        error_count = error_count + 1;
                    end
                    if (width_overflow !== want.width_overflow)
                    begin
                        $error("width_overflow: expected %b, got %b",
                               want.width_overflow, width_overflow);
                        error_count = error_count + 1;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_for_drain();
        while (text_items_q.size() != 0 || in_valid || expanded_results_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        queue_directed_text();
        queue_random_text(ITEMS_PER_SET);
        rst_n = 1'b1;
        wait_for_drain();

        tx_idle_pct = 58;
        rx_idle_pct = 37;
        queue_random_text(ITEMS_PER_SET);
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_text(ITEMS_PER_SET);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/uxw_pkg.sv
hw/rtl/uxw_front.sv
hw/rtl/uxw_queue.sv
hw/rtl/uxw_back.sv
hw/rtl/utf8_tab_expand_width.sv
hw/rtl/uxw_checker.sv
sim/tb.sv
